/* rtl/core/quaternion_to_euler_defines.svh */
// Assertion helpers shared by the quaternion to Euler checker.
`ifndef QUATERNION_TO_EULER_DEFINES_SVH
`define QUATERNION_TO_EULER_DEFINES_SVH

// Clocked check, switched off while reset is held
`define QTE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define QTE_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/qte_pkg.sv */
package qte_pkg;

	// Operand widths
	localparam int ARG_W     = 34;   // atan2 operands and pitch cross term
	localparam int N_W       = 33;   // squared norm, unsigned
	localparam int CW        = 40;   // CORDIC x/y with growth headroom
	localparam int ZW        = 32;   // angles, radians in units of 2^-28
	localparam int DIV_BITS  = 30;   // quotient bits of the pitch ratio
	localparam int ROOT_BITS = DIV_BITS + 1;
	localparam int PITCH_LAT = DIV_BITS + ROOT_BITS + 3;
	localparam int ATAN_LEN  = 24;

	localparam logic signed [ZW-1:0] PI_Q28      = 32'sd843314857;
	localparam logic signed [ZW-1:0] HALF_PI_Q28 = 32'sd421657428;
	// round(180/pi * 2^24)
	localparam logic signed [31:0]   DEG_K       = 32'sd961263669;

	typedef struct packed {
		logic signed [15:0] quat_real;
		logic signed [15:0] quat_i;
		logic signed [15:0] quat_j;
		logic signed [15:0] quat_k;
	} in_t;

	typedef struct packed {
		logic signed [15:0] yaw_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] roll_angle;
		logic               zero_norm;
	} out_t;

	// atan(2^-i) * 2^28, rounded
	function automatic logic signed [ZW-1:0] atan_entry(input int idx);
		logic signed [ZW-1:0] v;
		case (idx)
			0:  v = 32'sd210828714;
			1:  v = 32'sd124459457;
			2:  v = 32'sd65760959;
			3:  v = 32'sd33381290;
			4:  v = 32'sd16755422;
			5:  v = 32'sd8385879;
			6:  v = 32'sd4193963;
			7:  v = 32'sd2097109;
			8:  v = 32'sd1048571;
			9:  v = 32'sd524287;
			10: v = 32'sd262144;
			11: v = 32'sd131072;
			12: v = 32'sd65536;
			13: v = 32'sd32768;
			14: v = 32'sd16384;
			15: v = 32'sd8192;
			16: v = 32'sd4096;
			17: v = 32'sd2048;
			18: v = 32'sd1024;
			19: v = 32'sd512;
			20: v = 32'sd256;
			21: v = 32'sd128;
			22: v = 32'sd64;
			23: v = 32'sd32;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* rtl/core/qte_cordic.sv */
// Vectoring CORDIC atan2, one iteration per register stage
module qte_cordic import qte_pkg::*; #(
	parameter int STAGES = 16
) (
	input  logic                    clk,
	input  logic                    adv,
	input  logic signed [ARG_W-1:0] y_in,
	input  logic signed [ARG_W-1:0] x_in,
	output logic signed [ZW-1:0]    z_out
);

	logic signed [CW-1:0] x_s  [STAGES+1];
	logic signed [CW-1:0] y_s  [STAGES+1];
	logic signed [ZW-1:0] z_s  [STAGES+1];
	logic                 zf_s [STAGES+1];

	// Pre-rotation by pi into the right half plane
	always_ff @(posedge clk) begin
		if (adv) begin
			zf_s[0] <= (x_in == 0) && (y_in == 0);
			if (x_in < 0) begin
				x_s[0] <= -CW'(x_in);
				y_s[0] <= -CW'(y_in);
				z_s[0] <= (y_in >= 0) ? PI_Q28 : -PI_Q28;
			end else begin
				x_s[0] <= CW'(x_in);
				y_s[0] <= CW'(y_in);
				z_s[0] <= '0;
			end
		end
	end

	// Micro-rotations
	for (genvar g = 0; g < STAGES; g++) begin : g_iter
		localparam logic signed [ZW-1:0] ANG = atan_entry(g);
		logic signed [CW-1:0] dx, dy;
		assign dx = y_s[g] >>> g;
		assign dy = x_s[g] >>> g;

		always_ff @(posedge clk) begin
			if (adv) begin
				zf_s[g+1] <= zf_s[g];
				if (y_s[g] >= 0) begin
					x_s[g+1] <= x_s[g] + dx;
					y_s[g+1] <= y_s[g] - dy;
					z_s[g+1] <= z_s[g] + ANG;
				end else begin
					x_s[g+1] <= x_s[g] - dx;
					y_s[g+1] <= y_s[g] + dy;
					z_s[g+1] <= z_s[g] - ANG;
				end
			end
		end
	end

	// Both operands zero gives a zero angle
	assign z_out = zf_s[STAGES] ? '0 : z_s[STAGES];

endmodule

/* rtl/core/qte_pitch.sv */
// Pitch operands: ratio |s|/n by restoring division, then the cosine
// term by a digit-by-digit square root; one bit per stage in both.
module qte_pitch import qte_pkg::*; (
	input  logic                    clk,
	input  logic                    adv,
	input  logic signed [ARG_W-1:0] s_in,
	input  logic        [N_W-1:0]   n_in,
	output logic signed [ARG_W-1:0] y_out,
	output logic signed [ARG_W-1:0] x_out,
	output logic                    clamp_out,
	output logic                    neg_out
);

	localparam int SQ_W = 2 * DIV_BITS;
	localparam int RV_W = SQ_W + 1;
	localparam int TW   = 2 * ROOT_BITS;

	// Divider stages
	logic [N_W-1:0]      rem_s   [DIV_BITS+1];
	logic [N_W-1:0]      n_s     [DIV_BITS+1];
	logic [DIV_BITS-1:0] q_s     [DIV_BITS+1];
	logic                neg_s   [DIV_BITS+1];
	logic                clamp_s [DIV_BITS+1];

	// Square and subtract stages
	logic [SQ_W-1:0]     sq_s;
	logic [DIV_BITS-1:0] qsq_s;
	logic                negsq_s, clampsq_s;

	// Root stages
	logic [RV_W-1:0]        rv_s   [ROOT_BITS+1];
	logic [ROOT_BITS-1:0]   res_s  [ROOT_BITS+1];
	logic signed [ARG_W-1:0] yr_s  [ROOT_BITS+1];
	logic                   clr_s  [ROOT_BITS+1];
	logic                   ngr_s  [ROOT_BITS+1];

	// Magnitude and sign of the cross term
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0]   <= N_W'(s_in < 0 ? -s_in : s_in);
			n_s[0]     <= n_in;
			q_s[0]     <= '0;
			neg_s[0]   <= s_in < 0;
			clamp_s[0] <= 1'b0;
		end
	end

	for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
		logic [N_W:0] t;
		logic         ge;
		assign t  = {rem_s[g], 1'b0};
		assign ge = t >= {1'b0, n_s[g]};

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[g+1] <= ge ? N_W'(t - {1'b0, n_s[g]}) : N_W'(t);
				q_s[g+1]   <= {q_s[g][DIV_BITS-2:0], ge};
				n_s[g+1]   <= n_s[g];
				neg_s[g+1] <= neg_s[g];
				if (g == 0) begin
					clamp_s[g+1] <= rem_s[g] >= n_s[g];
				end else begin
					clamp_s[g+1] <= clamp_s[g];
				end
			end
		end
	end

	// Ratio squared
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s      <= SQ_W'(q_s[DIV_BITS]) * SQ_W'(q_s[DIV_BITS]);
			qsq_s     <= q_s[DIV_BITS];
			negsq_s   <= neg_s[DIV_BITS];
			clampsq_s <= clamp_s[DIV_BITS];
		end
	end

	// Radicand 1 - r^2 and signed sine term
	always_ff @(posedge clk) begin
		if (adv) begin
			rv_s[0]  <= (RV_W'(1) << SQ_W) - RV_W'(sq_s);
			res_s[0] <= '0;
			yr_s[0]  <= negsq_s ? -ARG_W'(qsq_s) : ARG_W'(qsq_s);
			clr_s[0] <= clampsq_s;
			ngr_s[0] <= negsq_s;
		end
	end

	for (genvar j = 0; j < ROOT_BITS; j++) begin : g_root
		localparam int B = ROOT_BITS - 1 - j;
		logic [TW-1:0] trial;
		logic          ge;
		assign trial = (TW'(res_s[j]) << (B + 1)) | (TW'(1) << (2 * B));
		assign ge    = TW'(rv_s[j]) >= trial;

		always_ff @(posedge clk) begin
			if (adv) begin
				rv_s[j+1]  <= ge ? RV_W'(TW'(rv_s[j]) - trial) : rv_s[j];
				res_s[j+1] <= ge ? (res_s[j] | (ROOT_BITS'(1) << B)) : res_s[j];
				yr_s[j+1]  <= yr_s[j];
				clr_s[j+1] <= clr_s[j];
				ngr_s[j+1] <= ngr_s[j];
			end
		end
	end

	assign y_out     = yr_s[ROOT_BITS];
	assign x_out     = ARG_W'(res_s[ROOT_BITS]);
	assign clamp_out = clr_s[ROOT_BITS];
	assign neg_out   = ngr_s[ROOT_BITS];

endmodule

/* rtl/core/quaternion_to_euler.sv */
// Accepts one quaternion per cycle while the output is not stalled; the deepest path
// is the pitch chain (restoring division, then squaring, then square root, then
// CORDIC), one bit or one CORDIC iteration per stage.
// A held result stalls the whole pipeline; nothing is dropped or repeated.
// Reset clears every stage valid and sets the output format to radians.
module quaternion_to_euler import qte_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);

	localparam int CL  = CORDIC_STAGES + 1;
	localparam int LAT = 3 + PITCH_LAT + CL + 2;

	logic           adv;
	logic [LAT-1:0] vld_s;
	logic           deg_q;

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		logic signed [15:0] r;
		if (v > 64'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -64'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = 16'(v);
		end
		return r;
	endfunction

	// Global advance: move when the output slot is free or being taken
	assign adv       = !vld_s[LAT-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_s[LAT-1];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-2:0], in_valid};
		end
	end

	// Output format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= 1'b0;
		end else if (cfg_valid) begin
			deg_q <= cfg_data;
		end
	end

	// Stage 1: capture
	in_t in_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			in_s1 <= in_data;
		end
	end

	// Stage 2: products
	logic signed [31:0] sr_s2, si_s2, sj_s2, sk_s2;
	logic signed [31:0] ij_s2, kr_s2, jk_s2, ir_s2, jr_s2, ik_s2;
	logic               zero_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			sr_s2   <= in_s1.quat_real * in_s1.quat_real;
			si_s2   <= in_s1.quat_i * in_s1.quat_i;
			sj_s2   <= in_s1.quat_j * in_s1.quat_j;
			sk_s2   <= in_s1.quat_k * in_s1.quat_k;
			ij_s2   <= in_s1.quat_i * in_s1.quat_j;
			kr_s2   <= in_s1.quat_k * in_s1.quat_real;
			jk_s2   <= in_s1.quat_j * in_s1.quat_k;
			ir_s2   <= in_s1.quat_i * in_s1.quat_real;
			jr_s2   <= in_s1.quat_j * in_s1.quat_real;
			ik_s2   <= in_s1.quat_i * in_s1.quat_k;
			zero_s2 <= (in_s1.quat_real == 0) && (in_s1.quat_i == 0)
				&& (in_s1.quat_j == 0) && (in_s1.quat_k == 0);
		end
	end

	// Stage 3: sums of products
	logic signed [ARG_W-1:0] yaw_y_s3, yaw_x_s3, roll_y_s3, roll_x_s3, ps_s3;
	logic        [N_W-1:0]   n_s3;
	logic                    zero_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			yaw_y_s3  <= (ARG_W'(ij_s2) + ARG_W'(kr_s2)) <<< 1;
			yaw_x_s3  <= ARG_W'(si_s2) - ARG_W'(sj_s2) - ARG_W'(sk_s2) + ARG_W'(sr_s2);
			roll_y_s3 <= (ARG_W'(jk_s2) + ARG_W'(ir_s2)) <<< 1;
			roll_x_s3 <= ARG_W'(sk_s2) + ARG_W'(sr_s2) - ARG_W'(si_s2) - ARG_W'(sj_s2);
			ps_s3     <= (ARG_W'(jr_s2) - ARG_W'(ik_s2)) <<< 1;
			n_s3      <= N_W'(ARG_W'(sr_s2) + ARG_W'(si_s2) + ARG_W'(sj_s2)
				+ ARG_W'(sk_s2));
			zero_s3   <= zero_s2;
		end
	end

	// Yaw and roll arctangents
	logic signed [ZW-1:0] yaw_z, roll_z, pitch_z;
	qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
		.clk(clk), .adv(adv), .y_in(yaw_y_s3), .x_in(yaw_x_s3), .z_out(yaw_z)
	);
	qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
		.clk(clk), .adv(adv), .y_in(roll_y_s3), .x_in(roll_x_s3), .z_out(roll_z)
	);

	// Pitch: ratio and cosine, then arctangent
	logic signed [ARG_W-1:0] p_y, p_x;
	logic                    p_clamp, p_neg;
	qte_pitch u_pitch (
		.clk(clk), .adv(adv), .s_in(ps_s3), .n_in(n_s3),
		.y_out(p_y), .x_out(p_x), .clamp_out(p_clamp), .neg_out(p_neg)
	);
	qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch_cordic (
		.clk(clk), .adv(adv), .y_in(p_y), .x_in(p_x), .z_out(pitch_z)
	);

	// Delay lines to line up with the pitch path
	logic signed [ZW-1:0] yaw_d_s   [PITCH_LAT];
	logic signed [ZW-1:0] roll_d_s  [PITCH_LAT];
	logic                 zero_d_s  [PITCH_LAT+CL];
	logic                 clamp_d_s [CL];
	logic                 neg_d_s   [CL];
	always_ff @(posedge clk) begin
		if (adv) begin
			yaw_d_s[0]   <= yaw_z;
			roll_d_s[0]  <= roll_z;
			zero_d_s[0]  <= zero_s3;
			clamp_d_s[0] <= p_clamp;
			neg_d_s[0]   <= p_neg;
			for (int i = 1; i < PITCH_LAT; i++) begin
				yaw_d_s[i]  <= yaw_d_s[i-1];
				roll_d_s[i] <= roll_d_s[i-1];
			end
			for (int i = 1; i < PITCH_LAT + CL; i++) begin
				zero_d_s[i] <= zero_d_s[i-1];
			end
			for (int i = 1; i < CL; i++) begin
				clamp_d_s[i] <= clamp_d_s[i-1];
				neg_d_s[i]   <= neg_d_s[i-1];
			end
		end
	end

	// Stage 4: final angle selection and degree scaling product
	logic signed [ZW-1:0] ang [3];
	logic signed [ZW-1:0] ang_s4  [3];
	logic signed [63:0]   prod_s4 [3];
	logic                 zero_s4;

	always_comb begin
		ang[0] = yaw_d_s[PITCH_LAT-1];
		ang[1] = clamp_d_s[CL-1] ? (neg_d_s[CL-1] ? -HALF_PI_Q28 : HALF_PI_Q28)
			: pitch_z;
		ang[2] = roll_d_s[PITCH_LAT-1];
		if (zero_d_s[PITCH_LAT+CL-1]) begin
			ang[0] = '0;
			ang[1] = '0;
			ang[2] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s4 <= zero_d_s[PITCH_LAT+CL-1];
			for (int l = 0; l < 3; l++) begin
				ang_s4[l]  <= ang[l];
				prod_s4[l] <= 64'(ang[l]) * 64'(DEG_K);
			end
		end
	end

	// Stage 5: rounding, saturation, output register
	logic signed [15:0] fmt [3];
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (deg_q) begin
				fmt[l] = sat16((prod_s4[l] + (64'sd1 <<< 45)) >>> 46);
			end else begin
				fmt[l] = sat16((64'(ang_s4[l]) + 64'sd32768) >>> 16);
			end
		end
	end

	out_t out_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			out_s5.yaw_angle   <= fmt[0];
			out_s5.pitch_angle <= fmt[1];
			out_s5.roll_angle  <= fmt[2];
			out_s5.zero_norm   <= zero_s4;
		end
	end

	assign out_data = out_s5;

endmodule

/* rtl/core/qte_chk.sv */
`include "quaternion_to_euler_defines.svh"

// Port-level checks on the quaternion to Euler block
module qte_chk import qte_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data,
	input logic cfg_ready
);

	// A held result keeps its payload
	`QTE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

	// A zero quaternion gives zero angles
	`QTE_ASSERT(a_zero_angles, out_valid && out_data.zero_norm |-> out_data.yaw_angle == 0 && out_data.pitch_angle == 0 && out_data.roll_angle == 0, "zero norm with non-zero angle")

	// Input side only stalls when the result slot is full and not taken
	`QTE_ASSERT(a_ready_link, in_ready == (!out_valid || out_ready), "input ready not tied to output slot")

	// Format register is always writable
	`QTE_ASSERT_RST(a_cfg_ready, cfg_ready, "configuration port not ready")

	// No result during reset
	`QTE_ASSERT_RST(a_rst_quiet, !arst_n |-> !out_valid, "result shown during reset")

endmodule

bind quaternion_to_euler qte_chk u_chk (.*);
